>>> src/nmfr_pkg.sv
// ----------------------------------------------------------------------------
// nmfr_pkg
// Shared sizes, register codes and controller types for the motion field
// resampler.
// ----------------------------------------------------------------------------
package nmfr_pkg;

  localparam int SOURCE_TEXELS = 262144;
  localparam int MAX_DIMENSION = 4096;

  localparam int ADDR_W    = (SOURCE_TEXELS > 1) ? $clog2(SOURCE_TEXELS) : 1;
  localparam int QUO_W     = $clog2(MAX_DIMENSION);
  localparam int DIM_W     = QUO_W + 1;
  localparam int PROD_W    = QUO_W + DIM_W;
  localparam int CNT_W     = $clog2(QUO_W);

  localparam int SIZE_W    = 13;
  localparam int RATIO_W   = 20;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W = 3;
  localparam int IDX_W     = 18;
  localparam int VEC_W     = 16;
  localparam int OUT_W     = 24;
  localparam int PIX_W     = 24;
  localparam int FRAC_W    = 16;
  localparam int MUL_W     = VEC_W + RATIO_W + 1;

  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1 << FRAC_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_W   = 3'd0,
    REG_SRC_H   = 3'd1,
    REG_TGT_W   = 3'd2,
    REG_TGT_H   = 3'd3,
    REG_RATIO_H = 3'd4,
    REG_RATIO_V = 3'd5
  } nmfr_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRAP,
    ST_MULT,
    ST_DIV,
    ST_ADDR,
    ST_READ,
    ST_SCALE,
    ST_ROUND,
    ST_EMIT
  } nmfr_state_t;

  typedef struct packed {
    logic store;
    logic wrap;
    logic mult;
    logic div_step;
    logic addr;
    logic read;
    logic scale;
    logic round;
    logic emit;
  } nmfr_cmd_t;

  typedef struct packed {
    logic tgt_zero;
    logic div_last;
    logic out_free;
  } nmfr_sts_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [SIZE_W-1:0] v);
    logic [31:0] ext;
    ext = 32'(v);
    if (ext > 32'(MAX_DIMENSION)) begin
      return DIM_W'(MAX_DIMENSION);
    end
    return DIM_W'(ext);
  endfunction

endpackage

>>> src/nmfr_ctrl.sv
// ----------------------------------------------------------------------------
// nmfr_ctrl
// Sequencer for one input word at a time: store write, raster wrap, column
// and row division, store read, scaling and result hand-over.
// ----------------------------------------------------------------------------
module nmfr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_operation,
  output logic                in_ready,
  input  nmfr_pkg::nmfr_sts_t sts,
  output nmfr_pkg::nmfr_cmd_t cmd
);
  import nmfr_pkg::*;

  nmfr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_operation) state_nxt = ST_WRAP;
      end
      ST_WRAP:  state_nxt = sts.tgt_zero ? ST_EMIT : ST_MULT;
      ST_MULT:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (sts.div_last) state_nxt = ST_ADDR;
      end
      ST_ADDR:  state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.store = in_valid && !in_operation;
      end
      ST_WRAP:  cmd.wrap     = 1'b1;
      ST_MULT:  cmd.mult     = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_ADDR:  cmd.addr     = 1'b1;
      ST_READ:  cmd.read     = 1'b1;
      ST_SCALE: cmd.scale    = 1'b1;
      ST_ROUND: cmd.round    = 1'b1;
      ST_EMIT:  cmd.emit     = sts.out_free;
      default:  cmd          = '0;
    endcase
  end

endmodule

>>> src/nmfr_dpath.sv
// ----------------------------------------------------------------------------
// nmfr_dpath
// Registers, vector store, raster counters, radix-2 dividers for source
// column and row, address multiply, ratio multiply with rounding and the
// output register.
// ----------------------------------------------------------------------------
module nmfr_dpath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_write_enable,
  input  logic [nmfr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nmfr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [nmfr_pkg::IDX_W-1:0]           in_source_index,
  input  logic signed [nmfr_pkg::VEC_W-1:0]    in_vector_x,
  input  logic signed [nmfr_pkg::VEC_W-1:0]    in_vector_y,
  input  nmfr_pkg::nmfr_cmd_t                  cmd,
  output nmfr_pkg::nmfr_sts_t                  sts,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [nmfr_pkg::PIX_W-1:0]           out_pixel_number,
  output logic signed [nmfr_pkg::OUT_W-1:0]    out_scaled_x,
  output logic signed [nmfr_pkg::OUT_W-1:0]    out_scaled_y,
  output logic                                 out_frame_end
);
  import nmfr_pkg::*;

  localparam logic signed [MUL_W-1:0] HALF   = MUL_W'(1 << (FRAC_W - 1));
  localparam logic signed [MUL_W-1:0] SAT_HI = MUL_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [MUL_W-1:0] SAT_LO = -SAT_HI - MUL_W'(1);

  // configuration
  logic [SIZE_W-1:0]  src_w_r, src_h_r, tgt_w_r, tgt_h_r;
  logic [RATIO_W-1:0] ratio_h_r, ratio_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r   <= '0;
      src_h_r   <= '0;
      tgt_w_r   <= '0;
      tgt_h_r   <= '0;
      ratio_h_r <= RATIO_ONE;
      ratio_v_r <= RATIO_ONE;
    end else if (cfg_write_enable) begin
      unique case (nmfr_reg_t'(cfg_index))
        REG_SRC_W:   src_w_r   <= cfg_data[SIZE_W-1:0];
        REG_SRC_H:   src_h_r   <= cfg_data[SIZE_W-1:0];
        REG_TGT_W:   tgt_w_r   <= cfg_data[SIZE_W-1:0];
        REG_TGT_H:   tgt_h_r   <= cfg_data[SIZE_W-1:0];
        REG_RATIO_H: ratio_h_r <= cfg_data[RATIO_W-1:0];
        REG_RATIO_V: ratio_v_r <= cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] sw, sh, tw, th;
  assign sw = clamp_dim(src_w_r);
  assign sh = clamp_dim(src_h_r);
  assign tw = clamp_dim(tgt_w_r);
  assign th = clamp_dim(tgt_h_r);

  logic tgt_zero;
  assign tgt_zero = (tw == '0) || (th == '0);

  // vector store
  logic [2*VEC_W-1:0] mem [SOURCE_TEXELS];
  logic [31:0]        wr_ext;
  assign wr_ext = 32'(in_source_index);

  always_ff @(posedge clk) begin
    if (cmd.store && (wr_ext < 32'(SOURCE_TEXELS))) begin
      mem[wr_ext[ADDR_W-1:0]] <= {in_vector_y, in_vector_x};
    end
  end

  // raster position
  logic [QUO_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [PIX_W-1:0] cnt_r, cnt_nxt;
  logic             tz_r;
  logic             last;
  logic [DIM_W-1:0] col_inc;

  assign last    = ({1'b0, col_r} == tw - DIM_W'(1)) && ({1'b0, row_r} == th - DIM_W'(1));
  assign col_inc = {1'b0, col_r} + DIM_W'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    cnt_nxt = cnt_r;
    if (cmd.wrap) begin
      if (tgt_zero || ({1'b0, col_r} >= tw) || ({1'b0, row_r} >= th)) begin
        col_nxt = '0;
        row_nxt = '0;
        cnt_nxt = '0;
      end
    end else if (cmd.emit && !tz_r) begin
      if (last) begin
        col_nxt = '0;
        row_nxt = '0;
        cnt_nxt = '0;
      end else begin
        cnt_nxt = cnt_r + PIX_W'(1);
        if (col_inc >= tw) begin
          col_nxt = '0;
          row_nxt = row_r + QUO_W'(1);
        end else begin
          col_nxt = col_inc[QUO_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      cnt_r <= '0;
      tz_r  <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      cnt_r <= cnt_nxt;
      if (cmd.wrap) tz_r <= tgt_zero;
    end
  end

  // dividers: quotient bits shift in below the remaining dividend bits
  logic [PROD_W-1:0] prod_x, prod_y;
  logic [DIM_W-1:0]  rem_x_r, rem_y_r, rem_x_nxt, rem_y_nxt;
  logic [QUO_W-1:0]  quo_x_r, quo_y_r, quo_x_nxt, quo_y_nxt;
  logic [CNT_W-1:0]  div_cnt_r;

  assign prod_x = PROD_W'(col_r) * PROD_W'(sw);
  assign prod_y = PROD_W'(row_r) * PROD_W'(sh);

  function automatic logic [DIM_W+QUO_W-1:0] div_step(
    input logic [DIM_W-1:0] rem,
    input logic [QUO_W-1:0] quo,
    input logic [DIM_W-1:0] den
  );
    logic [DIM_W:0] trial;
    logic [DIM_W:0] diff;
    trial = {rem, quo[QUO_W-1]};
    diff  = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      return {diff[DIM_W-1:0], quo[QUO_W-2:0], 1'b1};
    end
    return {trial[DIM_W-1:0], quo[QUO_W-2:0], 1'b0};
  endfunction

  always_comb begin
    {rem_x_nxt, quo_x_nxt} = div_step(rem_x_r, quo_x_r, tw);
    {rem_y_nxt, quo_y_nxt} = div_step(rem_y_r, quo_y_r, th);
  end

  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      rem_x_r <= prod_x[PROD_W-1:QUO_W];
      quo_x_r <= prod_x[QUO_W-1:0];
      rem_y_r <= prod_y[PROD_W-1:QUO_W];
      quo_y_r <= prod_y[QUO_W-1:0];
    end else if (cmd.div_step) begin
      rem_x_r <= rem_x_nxt;
      quo_x_r <= quo_x_nxt;
      rem_y_r <= rem_y_nxt;
      quo_y_r <= quo_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.mult) begin
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + CNT_W'(1);
    end
  end

  // source address
  logic [QUO_W-1:0]  sx_c, sy_c;
  logic [PROD_W:0]   s_full;
  logic [31:0]       s_ext;
  logic [ADDR_W-1:0] addr_r;
  logic              ok_r;

  assign sx_c   = ({1'b0, quo_x_r} >= sw) ? QUO_W'(sw - DIM_W'(1)) : quo_x_r;
  assign sy_c   = ({1'b0, quo_y_r} >= sh) ? QUO_W'(sh - DIM_W'(1)) : quo_y_r;
  assign s_full = (PROD_W+1)'(sy_c) * (PROD_W+1)'(sw) + (PROD_W+1)'(sx_c);
  assign s_ext  = 32'(s_full);

  always_ff @(posedge clk) begin
    if (cmd.addr) begin
      addr_r <= s_ext[ADDR_W-1:0];
      ok_r   <= (sw != '0) && (sh != '0) && (s_ext < 32'(SOURCE_TEXELS));
    end
  end

  logic [2*VEC_W-1:0] rd_r;
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_r <= mem[addr_r];
    end
  end

  // scaling
  logic signed [MUL_W-1:0] mul_x_r, mul_y_r;
  logic signed [MUL_W-1:0] q_x, q_y;
  logic signed [OUT_W-1:0] res_x_r, res_y_r;

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      mul_x_r <= MUL_W'(signed'(rd_r[VEC_W-1:0])) * MUL_W'(signed'({1'b0, ratio_h_r}));
      mul_y_r <= MUL_W'(signed'(rd_r[2*VEC_W-1:VEC_W])) * MUL_W'(signed'({1'b0, ratio_v_r}));
    end
  end

  assign q_x = (mul_x_r + HALF) >>> FRAC_W;
  assign q_y = (mul_y_r + HALF) >>> FRAC_W;

  function automatic logic signed [OUT_W-1:0] sat(input logic signed [MUL_W-1:0] q);
    if (q > SAT_HI) return SAT_HI[OUT_W-1:0];
    if (q < SAT_LO) return SAT_LO[OUT_W-1:0];
    return q[OUT_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.round) begin
      res_x_r <= ok_r ? sat(q_x) : '0;
      res_y_r <= ok_r ? sat(q_y) : '0;
    end
  end

  // output register
  logic             out_valid_r;
  logic [PIX_W-1:0] out_pix_r;
  logic [OUT_W-1:0] out_x_r, out_y_r;
  logic             out_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_pix_r <= tz_r ? '0 : cnt_r;
      out_x_r   <= tz_r ? '0 : res_x_r;
      out_y_r   <= tz_r ? '0 : res_y_r;
      out_end_r <= tz_r | last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_number = out_pix_r;
  assign out_scaled_x     = signed'(out_x_r);
  assign out_scaled_y     = signed'(out_y_r);
  assign out_frame_end    = out_end_r;

  assign sts.tgt_zero = tgt_zero;
  assign sts.div_last = (div_cnt_r == CNT_W'(QUO_W - 1));
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

>>> src/nearest_motion_field_resampler_unit.sv
// ----------------------------------------------------------------------------
// nearest_motion_field_resampler_unit
// Nearest-neighbour resampler for a two-component motion-vector field. A word
// with operation 0 writes one vector into the source store. A word with
// operation 1 produces the next destination pixel in raster order: source
// column and row come from two radix-2 dividers running side by side, one
// quotient bit per cycle, and the fetched vector is scaled by the Q4.16
// ratios with round-half-up and saturation. A pixel word holds the unit,
// before the next word is taken, through division, store read, scaling and
// rounding, and then until the output register is free of its last result.
// Zero target size gives a zero vector at pixel 0 flagged as frame end; zero
// source size gives zero vectors. Store entries must be written before use.
// ----------------------------------------------------------------------------
module nearest_motion_field_resampler_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_write_enable,
  input  logic [nmfr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nmfr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_operation,
  input  logic [nmfr_pkg::IDX_W-1:0]           in_source_index,
  input  logic signed [nmfr_pkg::VEC_W-1:0]    in_vector_x,
  input  logic signed [nmfr_pkg::VEC_W-1:0]    in_vector_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [nmfr_pkg::PIX_W-1:0]           out_pixel_number,
  output logic signed [nmfr_pkg::OUT_W-1:0]    out_scaled_x,
  output logic signed [nmfr_pkg::OUT_W-1:0]    out_scaled_y,
  output logic                                 out_frame_end
);
  import nmfr_pkg::*;

  nmfr_cmd_t cmd;
  nmfr_sts_t sts;

  nmfr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  nmfr_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_source_index  (in_source_index),
    .in_vector_x      (in_vector_x),
    .in_vector_y      (in_vector_y),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_number (out_pixel_number),
    .out_scaled_x     (out_scaled_x),
    .out_scaled_y     (out_scaled_y),
    .out_frame_end    (out_frame_end)
  );

endmodule

>>> dv/nearest_motion_field_resampler_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_motion_field_resampler_unit_test
// Self-checking bench for the motion field resampler. Source vector writes and
// next-pixel requests run over many field geometries and axis ratios. Each
// pixel word is checked field by field against a behavioural raster predictor.
// Both channels stall at random, and the output is held off once for a long
// stretch.
// ----------------------------------------------------------------------------
module nearest_motion_field_resampler_unit_test;
  import nmfr_pkg::*;

  localparam bit OP_WRITE = 1'b0;
  localparam bit OP_PIXEL = 1'b1;
  localparam logic [RATIO_W-1:0] RATIO_MAX = '1;
  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_PHASES = 21;
  localparam int PHASE_WORDS = 37;
  localparam int HOLD_PHASE = 16;
  localparam int REPORT_LINES = 100;

  typedef struct {
    bit                     op;
    bit [IDX_W-1:0]         texel_index;
    bit signed [VEC_W-1:0]  vx;
    bit signed [VEC_W-1:0]  vy;
  } field_word_t;

  typedef struct {
    bit [PIX_W-1:0]         pixel;
    bit signed [OUT_W-1:0]  sx;
    bit signed [OUT_W-1:0]  sy;
    bit                     last;
  } pixel_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_write_enable = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_operation = 1'b0;
  logic [IDX_W-1:0]        in_source_index = '0;
  logic signed [VEC_W-1:0] in_vector_x = '0;
  logic signed [VEC_W-1:0] in_vector_y = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [PIX_W-1:0]        out_pixel_number;
  logic signed [OUT_W-1:0] out_scaled_x;
  logic signed [OUT_W-1:0] out_scaled_y;
  logic                    out_frame_end;

  bit [SIZE_W-1:0]  src_w_cfg, src_h_cfg, tgt_w_cfg, tgt_h_cfg;
  bit [RATIO_W-1:0] ratio_h_cfg = RATIO_ONE;
  bit [RATIO_W-1:0] ratio_v_cfg = RATIO_ONE;

  int             raster_col, raster_row;
  bit [PIX_W-1:0] raster_count;
  bit [31:0]      texel_mem [int];
  bit             texel_written [int];

  field_word_t    stimulus_words [$];
  pixel_result_t  pending_pixels [$];
  field_word_t    on_bus;

  int send_idle_pct = 6;
  int recv_idle_pct = 72;
  bit stall_phase = 1'b0;
  bit stall_done = 1'b0;
  int hold_left = 0;

  int mismatches, source_writes, pixels_checked, frame_ends, settings_used;

  always #10 clk = ~clk;

  nearest_motion_field_resampler_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_source_index  (in_source_index),
    .in_vector_x      (in_vector_x),
    .in_vector_y      (in_vector_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_number (out_pixel_number),
    .out_scaled_x     (out_scaled_x),
    .out_scaled_y     (out_scaled_y),
    .out_frame_end    (out_frame_end)
  );

  function automatic int clip_size(input bit [SIZE_W-1:0] v);
    return (v > MAX_DIMENSION) ? MAX_DIMENSION : int'(v);
  endfunction

  // round half up, then saturate to the output width
  function automatic bit signed [OUT_W-1:0] rescale(input bit signed [VEC_W-1:0] v,
                                                    input bit [RATIO_W-1:0] ratio);
    longint p;
    p = (longint'(v) * longint'(ratio) + 32768) >>> FRAC_W;
    if (p > 8388607) p = 8388607;
    else if (p < -8388608) p = -8388608;
    return p[OUT_W-1:0];
  endfunction

  task automatic resample_step(input field_word_t w);
    int            sw, sh, tw, th, src_col, src_row;
    longint        texel;
    bit [31:0]     packed_vec;
    pixel_result_t r;
    if (w.op == OP_WRITE) begin
      if (w.texel_index < SOURCE_TEXELS) texel_mem[int'(w.texel_index)] = {w.vy, w.vx};
      source_writes++;
      return;
    end
    sw = clip_size(src_w_cfg);
    sh = clip_size(src_h_cfg);
    tw = clip_size(tgt_w_cfg);
    th = clip_size(tgt_h_cfg);
    r = '{default: 0};
    if (tw == 0 || th == 0) begin
      raster_col = 0;
      raster_row = 0;
      raster_count = '0;
      r.last = 1'b1;
      pending_pixels = {pending_pixels, r};
      return;
    end
    if (raster_col >= tw || raster_row >= th) begin
      raster_col = 0;
      raster_row = 0;
      raster_count = '0;
    end
    if (sw != 0 && sh != 0) begin
      src_col = raster_col * sw / tw;
      src_row = raster_row * sh / th;
      if (src_col >= sw) src_col = sw - 1;
      if (src_row >= sh) src_row = sh - 1;
      texel = longint'(src_row) * sw + src_col;
      if (texel < SOURCE_TEXELS) begin
        packed_vec = texel_mem.exists(int'(texel)) ? texel_mem[int'(texel)] : '0;
        r.sx = rescale(packed_vec[15:0], ratio_h_cfg);
        r.sy = rescale(packed_vec[31:16], ratio_v_cfg);
      end
    end
    r.pixel = raster_count;
    r.last = (raster_col == tw - 1) && (raster_row == th - 1);
    pending_pixels = {pending_pixels, r};
    if (r.last) begin
      raster_col = 0;
      raster_row = 0;
      raster_count = '0;
    end else begin
      raster_col++;
      if (raster_col >= tw) begin
        raster_col = 0;
        raster_row++;
      end
      raster_count++;
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= REPORT_LINES)
      $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_result();
    pixel_result_t want;
    if (pending_pixels.size() == 0) begin
      report_mismatch("unrequested pixel word", longint'(out_pixel_number), -1);
      return;
    end
    want = pending_pixels.pop_front();
    if (out_pixel_number !== want.pixel)
      report_mismatch("pixel_number", out_pixel_number, want.pixel);
    if (out_scaled_x !== want.sx) report_mismatch("scaled_x", out_scaled_x, want.sx);
    if (out_scaled_y !== want.sy) report_mismatch("scaled_y", out_scaled_y, want.sy);
    if (out_frame_end !== want.last) report_mismatch("frame_end", out_frame_end, want.last);
    pixels_checked++;
    if (want.last) frame_ends++;
  endtask

  function automatic bit signed [VEC_W-1:0] any_component();
    case ($urandom_range(9))
      0:       return VEC_W'(-32768);
      1:       return VEC_W'(32767);
      default: return VEC_W'($urandom);
    endcase
  endfunction

  function automatic bit [SIZE_W-1:0] pick_source();
    return ($urandom_range(9) == 0) ? '0 : SIZE_W'($urandom_range(1, 8));
  endfunction

  function automatic bit [SIZE_W-1:0] pick_target();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 12) return SIZE_W'($urandom_range(MAX_DIMENSION, 8191));
    return SIZE_W'($urandom_range(1, 12));
  endfunction

  function automatic bit [RATIO_W-1:0] pick_ratio();
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) return '0;
    if (roll < 30) return RATIO_MAX;
    if (roll < 45) return RATIO_ONE;
    return RATIO_W'($urandom);
  endfunction

  task automatic queue_write(input int idx, input int vx, input int vy);
    field_word_t w;
    w.op = OP_WRITE;
    w.texel_index = IDX_W'(idx);
    w.vx = VEC_W'(vx);
    w.vy = VEC_W'(vy);
    stimulus_words = {stimulus_words, w};
    texel_written[idx] = 1'b1;
  endtask

  task automatic queue_pixel();
    field_word_t w;
    w.op = OP_PIXEL;
    w.texel_index = IDX_W'($urandom);
    w.vx = any_component();
    w.vy = any_component();
    stimulus_words = {stimulus_words, w};
  endtask

  task automatic write_register(input nmfr_reg_t r, input bit [CFG_DATA_W-1:0] v);
    @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    case (r)
      REG_SRC_W:   src_w_cfg = v[SIZE_W-1:0];
      REG_SRC_H:   src_h_cfg = v[SIZE_W-1:0];
      REG_TGT_W:   tgt_w_cfg = v[SIZE_W-1:0];
      REG_TGT_H:   tgt_h_cfg = v[SIZE_W-1:0];
      REG_RATIO_H: ratio_h_cfg = v[RATIO_W-1:0];
      REG_RATIO_V: ratio_v_cfg = v[RATIO_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic program_field(input int sw, input int sh, input int tw, input int th,
                               input int rh, input int rv);
    write_register(REG_SRC_W, CFG_DATA_W'(sw));
    write_register(REG_SRC_H, CFG_DATA_W'(sh));
    write_register(REG_TGT_W, CFG_DATA_W'(tw));
    write_register(REG_TGT_H, CFG_DATA_W'(th));
    write_register(REG_RATIO_H, CFG_DATA_W'(rh));
    write_register(REG_RATIO_V, CFG_DATA_W'(rv));
    settings_used++;
  endtask

  // idle once nothing is queued, on the bus or outstanding, plus pipeline settle
  task automatic drain();
    do @(negedge clk);
    while (stimulus_words.size() != 0 || in_valid || pending_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) resample_step(on_bus);
      if (!in_valid || in_ready) begin
        if (stimulus_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = stimulus_words.pop_front();
          in_valid <= 1'b1;
          in_operation <= on_bus.op;
          in_source_index <= on_bus.texel_index;
          in_vector_x <= on_bus.vx;
          in_vector_y <= on_bus.vy;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (stall_phase && !stall_done) begin
        hold_left = HOLD_CYCLES;
        stall_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL nearest_motion_field_resampler_unit");
    $finish;
  end

  initial begin : sequencer
    int              area, roll;
    bit [SIZE_W-1:0] sw, sh;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset geometry has zero target: pixel word is a lone frame end
    queue_write(0, -32768, 32767);
    queue_write(SOURCE_TEXELS - 1, 32767, -32768);
    queue_write(1, -1, 1);
    queue_write(2, 1, -1);
    queue_write(3, 16'sh5555, -16'sh5556);
    queue_pixel();
    drain();

    program_field(2, 2, 3, 2, RATIO_MAX, '0);
    repeat (6) queue_pixel();
    drain();

    program_field(0, 2, 2, 1, '0, RATIO_MAX);
    repeat (2) queue_pixel();
    drain();

    // oversized source: second row lands beyond the store
    program_field(8191, 4096, 1, 2, RATIO_ONE, RATIO_ONE);
    repeat (3) queue_pixel();
    drain();

    // half ratio for rounding ties; shrinking target restarts the raster
    program_field(1, 1, 8191, 1, RATIO_ONE >> 1, RATIO_ONE >> 1);
    queue_write(0, -1, 1);
    repeat (2) queue_pixel();
    drain();

    program_field(1, 1, 1, 8191, RATIO_ONE, RATIO_MAX);
    repeat (2) queue_pixel();
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES / 3) begin
        send_idle_pct = 72;
        recv_idle_pct = 6;
      end
      if (p == 2 * RANDOM_PHASES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      stall_phase = (p == HOLD_PHASE);
      sw = pick_source();
      sh = pick_source();
      program_field(sw, sh, pick_target(), pick_target(), pick_ratio(), pick_ratio());
      area = int'(sw) * int'(sh);
      for (int i = 0; i < area; i++) begin
        if (!texel_written.exists(i) || $urandom_range(1) == 1)
          queue_write(i, any_component(), any_component());
      end
      repeat (PHASE_WORDS) begin
        roll = $urandom_range(99);
        if (roll < 78) queue_pixel();
        else if (roll < 90 && area != 0)
          queue_write($urandom_range(0, area - 1), any_component(), any_component());
        else
          queue_write($urandom_range(0, SOURCE_TEXELS - 1), any_component(), any_component());
      end
      drain();
    end

    $display("Run covered %0d source writes and %0d checked pixels (%0d frame ends)",
             source_writes, pixels_checked, frame_ends);
    $display("over %0d geometries, with random stalls both ways and a long output hold-off.",
             settings_used);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("PASS nearest_motion_field_resampler_unit");
    end else begin
      $display("FAIL nearest_motion_field_resampler_unit");
    end
    $finish;
  end

endmodule
